/* sv/fsgc_pkg.sv */
// ----------------------------------------------------------------------------
// Flash segment garbage collector package
// Shared types, field widths and codes for the collector and its page tables.
// ----------------------------------------------------------------------------
package fsgc_pkg;

    localparam int OP_W         = 2;
    localparam int KIND_W       = 2;
    localparam int PAGE_FIELD_W = 10;
    localparam int SEG_FIELD_W  = 5;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 40;
    // Wide enough for the largest victim start before reduction (31 * 32 at the default segment size).
    localparam int NORM_W       = 11;

    typedef enum logic [OP_W-1:0] {
        OP_MAP_WRITE  = 2'd0,
        OP_INVALIDATE = 2'd1,
        OP_COLLECT    = 2'd2,
        OP_LOOKUP     = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_COPY   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NORM,
        ST_EXEC,
        ST_WALK,
        ST_DONE,
        ST_LOOK_OUT
    } state_t;

    typedef enum logic [1:0] {
        NS_PHYS,
        NS_LOGI,
        NS_START
    } norm_sel_t;

    typedef struct packed {
        logic l2p_we;
        logic own_we;
        logic inv_we;
        logic inv_wdata;
        logic l2p_re;
        logic walk_re;
    } tbl_ctrl_t;

endpackage

/* sv/fsgc_tables.sv */
// ----------------------------------------------------------------------------
// Page tables
// Logical-to-physical map, page owner map and invalid-page bitmap, each a
// single-port-write memory with a registered read.
// ----------------------------------------------------------------------------
module fsgc_tables #(
    parameter int TOTAL_PAGES = 1024
) (
    input  logic                            clk,
    input  fsgc_pkg::tbl_ctrl_t             ctrl,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  l2p_waddr,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  l2p_wdata,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  own_waddr,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  own_wdata,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  inv_waddr,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  l2p_raddr,
    input  logic [$clog2(TOTAL_PAGES)-1:0]  walk_raddr,
    output logic [$clog2(TOTAL_PAGES)-1:0]  l2p_rdata,
    output logic [$clog2(TOTAL_PAGES)-1:0]  own_rdata,
    output logic                            inv_rdata
);
    import fsgc_pkg::*;

    localparam int PW = $clog2(TOTAL_PAGES);

    logic [PW-1:0] l2p_mem [TOTAL_PAGES];
    logic [PW-1:0] own_mem [TOTAL_PAGES];
    logic          inv_mem [TOTAL_PAGES];

    always_ff @(posedge clk)
    begin
        if (ctrl.l2p_we)
        begin
            l2p_mem[l2p_waddr] <= l2p_wdata;
        end
        if (ctrl.l2p_re)
        begin
            l2p_rdata <= l2p_mem[l2p_raddr];
        end
    end

    // The owner read passes a write to the same page straight through, since
    // a copy may land on the very page that the walk reads next.
    always_ff @(posedge clk)
    begin
        if (ctrl.own_we)
        begin
            own_mem[own_waddr] <= own_wdata;
        end
        if (ctrl.walk_re)
        begin
            if (ctrl.own_we && (own_waddr == walk_raddr))
            begin
                own_rdata <= own_wdata;
            end
            else
            begin
                own_rdata <= own_mem[walk_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.inv_we)
        begin
            inv_mem[inv_waddr] <= ctrl.inv_wdata;
        end
        if (ctrl.walk_re)
        begin
            inv_rdata <= inv_mem[walk_raddr];
        end
    end

endmodule

/* sv/flash_segment_garbage_collector.sv */
// ----------------------------------------------------------------------------
// Flash segment garbage collector
// Page-mapped translation tables with a segment collector driven by a small
// sequencer around one shared compare-subtract unit.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_ stream (opcode in s_tuser) and results
// leave on the m_ stream (result kind in m_tuser, last result in m_tlast).
// Map write and invalidate give no result; lookup gives one; collect gives
// one copy item per valid page of the victim segment and then one
// trim-and-done item with m_tlast high.
// Each command first has its page numbers reduced modulo TOTAL_PAGES by the
// shared subtractor, one page number after another. The walk reads one page
// of the owner map and bitmap per cycle unless a full output register holds
// it on a valid page. Only one command is worked on at a time and s_tready
// is low until it finishes.
// Results sit in an output register; while m_tready is low the walk halts
// on the next valid page and resumes when the register drains.
// After reset the tables are cleared in a pass over all TOTAL_PAGES pages
// with s_tready low.
// ----------------------------------------------------------------------------
module flash_segment_garbage_collector #(
    parameter int PAGES_PER_SEGMENT = 32,
    parameter int TOTAL_PAGES       = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode
    input  logic [fsgc_pkg::OP_W-1:0]           s_tuser,
    // physical_page [9:0], logical_page [19:10], victim_segment [24:20]
    input  logic [fsgc_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_kind
    output logic [fsgc_pkg::KIND_W-1:0]         m_tuser,
    // source_page [9:0], dest_page [19:10], moved_logical_page [29:20],
    // log_segment_out [34:30]
    output logic [fsgc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import fsgc_pkg::*;

    localparam int PW = $clog2(TOTAL_PAGES);
    localparam int CW = $clog2(PAGES_PER_SEGMENT);

    state_t                     state_reg, state_next;
    norm_sel_t                  sel_reg, sel_next;
    op_t                        op_reg, op_next;
    logic [NORM_W-1:0]          pp_reg, pp_next;
    logic [NORM_W-1:0]          lp_reg, lp_next;
    logic [NORM_W-1:0]          st_reg, st_next;
    logic [SEG_FIELD_W-1:0]     vic_reg, vic_next;
    logic [SEG_FIELD_W-1:0]     log_reg, log_next;
    logic [PW-1:0]              p_reg, p_next;
    logic [PW-1:0]              dest_reg, dest_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       copied_reg, copied_next;
    logic [PW-1:0]              clr_reg, clr_next;

    logic                       ovalid_reg, ovalid_next;
    kind_t                      okind_reg, okind_next;
    logic [PAGE_FIELD_W-1:0]    osrc_reg, osrc_next;
    logic [PAGE_FIELD_W-1:0]    odst_reg, odst_next;
    logic [PAGE_FIELD_W-1:0]    omov_reg, omov_next;
    logic [SEG_FIELD_W-1:0]     oseg_reg, oseg_next;
    logic                       olast_reg, olast_next;

    logic                       accept;
    logic                       out_free;
    logic                       emit;
    logic [NORM_W-1:0]          norm_cur;
    logic                       norm_ge;
    logic [NORM_W-1:0]          norm_diff;
    logic [PW-1:0]              pp_a, lp_a, st_a;
    logic [PW-1:0]              p_inc, dest_inc;
    logic                       cnt_last;
    logic                       clr_last;
    logic                       walk_go;

    tbl_ctrl_t                  tctrl;
    logic [PW-1:0]              l2p_waddr, l2p_wdata, own_waddr, own_wdata, inv_waddr;
    logic [PW-1:0]              l2p_raddr, walk_raddr;
    logic [PW-1:0]              l2p_rdata, own_rdata;
    logic                       inv_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !ovalid_reg || m_tready;

    // Shared compare-subtract unit for the modulo reduction.
    always_comb
    begin
        unique case (sel_reg)
            NS_PHYS:  norm_cur = pp_reg;
            NS_LOGI:  norm_cur = lp_reg;
            NS_START: norm_cur = st_reg;
            default:  norm_cur = st_reg;
        endcase
    end
    assign norm_ge   = (32'(norm_cur) >= TOTAL_PAGES);
    assign norm_diff = norm_cur - NORM_W'(TOTAL_PAGES);

    assign pp_a = PW'(pp_reg);
    assign lp_a = PW'(lp_reg);
    assign st_a = PW'(st_reg);

    assign p_inc    = (32'(p_reg) + 1 == TOTAL_PAGES) ? '0 : PW'(p_reg + 1'b1);
    assign dest_inc = (32'(dest_reg) + 1 == TOTAL_PAGES) ? '0 : PW'(dest_reg + 1'b1);
    assign cnt_last = (cnt_reg == CW'(PAGES_PER_SEGMENT - 1));
    assign clr_last = (32'(clr_reg) == TOTAL_PAGES - 1);
    assign walk_go  = inv_rdata || out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!norm_ge && (sel_reg == NS_START))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_COLLECT: state_next = ST_WALK;
                    OP_LOOKUP:  state_next = ST_LOOK_OUT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_WALK:
            begin
                if (walk_go && cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, table accesses and result register loads.
    always_comb
    begin
        sel_next    = sel_reg;
        op_next     = op_reg;
        pp_next     = pp_reg;
        lp_next     = lp_reg;
        st_next     = st_reg;
        vic_next    = vic_reg;
        log_next    = log_reg;
        p_next      = p_reg;
        dest_next   = dest_reg;
        cnt_next    = cnt_reg;
        copied_next = copied_reg;
        clr_next    = clr_reg;

        tctrl      = '0;
        l2p_waddr  = lp_a;
        l2p_wdata  = pp_a;
        own_waddr  = pp_a;
        own_wdata  = lp_a;
        inv_waddr  = pp_a;
        l2p_raddr  = lp_a;
        walk_raddr = p_inc;

        emit       = 1'b0;
        okind_next = okind_reg;
        osrc_next  = osrc_reg;
        odst_next  = odst_reg;
        omov_next  = omov_reg;
        oseg_next  = oseg_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tctrl.l2p_we    = 1'b1;
                tctrl.own_we    = 1'b1;
                tctrl.inv_we    = 1'b1;
                tctrl.inv_wdata = 1'b0;
                l2p_waddr       = clr_reg;
                l2p_wdata       = '0;
                own_waddr       = clr_reg;
                own_wdata       = '0;
                inv_waddr       = clr_reg;
                clr_next        = PW'(clr_reg + 1'b1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(s_tuser);
                    pp_next  = NORM_W'(s_tdata[PAGE_FIELD_W-1:0]);
                    lp_next  = NORM_W'(s_tdata[2*PAGE_FIELD_W-1:PAGE_FIELD_W]);
                    vic_next = s_tdata[2*PAGE_FIELD_W+SEG_FIELD_W-1:2*PAGE_FIELD_W];
                    st_next  = NORM_W'(s_tdata[2*PAGE_FIELD_W+SEG_FIELD_W-1:2*PAGE_FIELD_W]
                                       * PAGES_PER_SEGMENT);
                    sel_next = NS_PHYS;
                end
            end
            ST_NORM:
            begin
                if (norm_ge)
                begin
                    unique case (sel_reg)
                        NS_PHYS:  pp_next = norm_diff;
                        NS_LOGI:  lp_next = norm_diff;
                        NS_START: st_next = norm_diff;
                        default:  st_next = norm_diff;
                    endcase
                end
                else
                begin
                    unique case (sel_reg)
                        NS_PHYS:  sel_next = NS_LOGI;
                        NS_LOGI:  sel_next = NS_START;
                        NS_START: sel_next = NS_START;
                        default:  sel_next = NS_START;
                    endcase
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_MAP_WRITE:
                    begin
                        tctrl.l2p_we    = 1'b1;
                        tctrl.own_we    = 1'b1;
                        tctrl.inv_we    = 1'b1;
                        tctrl.inv_wdata = 1'b0;
                    end
                    OP_INVALIDATE:
                    begin
                        tctrl.inv_we    = 1'b1;
                        tctrl.inv_wdata = 1'b1;
                    end
                    OP_COLLECT:
                    begin
                        tctrl.walk_re = 1'b1;
                        walk_raddr    = st_a;
                        p_next        = st_a;
                        dest_next     = pp_a;
                        cnt_next      = '0;
                        copied_next   = 1'b0;
                    end
                    OP_LOOKUP:
                    begin
                        tctrl.l2p_re = 1'b1;
                    end
                    default:
                    begin
                        tctrl.l2p_re = 1'b0;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (walk_go)
                begin
                    // The walked page's bit is cleared as it goes by.
                    tctrl.inv_we    = 1'b1;
                    tctrl.inv_wdata = 1'b0;
                    inv_waddr       = p_reg;
                    if (!inv_rdata)
                    begin
                        tctrl.l2p_we = 1'b1;
                        tctrl.own_we = 1'b1;
                        l2p_waddr    = own_rdata;
                        l2p_wdata    = dest_reg;
                        own_waddr    = dest_reg;
                        own_wdata    = own_rdata;
                        emit         = 1'b1;
                        okind_next   = KIND_COPY;
                        osrc_next    = PAGE_FIELD_W'(p_reg);
                        odst_next    = PAGE_FIELD_W'(dest_reg);
                        omov_next    = PAGE_FIELD_W'(own_rdata);
                        oseg_next    = log_reg;
                        olast_next   = 1'b0;
                        dest_next    = dest_inc;
                        copied_next  = 1'b1;
                    end
                    if (!cnt_last)
                    begin
                        tctrl.walk_re = 1'b1;
                        p_next        = p_inc;
                        cnt_next      = CW'(cnt_reg + 1'b1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    okind_next = KIND_DONE;
                    osrc_next  = PAGE_FIELD_W'(st_a);
                    odst_next  = copied_reg ? PAGE_FIELD_W'(dest_reg) : PAGE_FIELD_W'(st_a);
                    omov_next  = '0;
                    oseg_next  = copied_reg ? vic_reg : log_reg;
                    olast_next = 1'b1;
                    log_next   = copied_reg ? vic_reg : log_reg;
                end
            end
            ST_LOOK_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    okind_next = KIND_LOOKUP;
                    osrc_next  = '0;
                    odst_next  = PAGE_FIELD_W'(l2p_rdata);
                    omov_next  = '0;
                    oseg_next  = log_reg;
                    olast_next = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            log_reg    <= '0;
            ovalid_reg <= 1'b0;
            sel_reg    <= NS_PHYS;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            log_reg    <= log_next;
            ovalid_reg <= ovalid_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pp_reg     <= pp_next;
        lp_reg     <= lp_next;
        st_reg     <= st_next;
        vic_reg    <= vic_next;
        p_reg      <= p_next;
        dest_reg   <= dest_next;
        cnt_reg    <= cnt_next;
        copied_reg <= copied_next;
        okind_reg  <= okind_next;
        osrc_reg   <= osrc_next;
        odst_reg   <= odst_next;
        omov_reg   <= omov_next;
        oseg_reg   <= oseg_next;
        olast_reg  <= olast_next;
    end

    fsgc_tables #(
        .TOTAL_PAGES (TOTAL_PAGES)
    ) u_tables (
        .clk        (clk),
        .ctrl       (tctrl),
        .l2p_waddr  (l2p_waddr),
        .l2p_wdata  (l2p_wdata),
        .own_waddr  (own_waddr),
        .own_wdata  (own_wdata),
        .inv_waddr  (inv_waddr),
        .l2p_raddr  (l2p_raddr),
        .walk_raddr (walk_raddr),
        .l2p_rdata  (l2p_rdata),
        .own_rdata  (own_rdata),
        .inv_rdata  (inv_rdata)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{(M_DATA_W - 3*PAGE_FIELD_W - SEG_FIELD_W){1'b0}},
                       oseg_reg, omov_reg, odst_reg, osrc_reg};

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Flash segment garbage collector testbench
// Streams map write, invalidate, lookup and collect commands into the block,
// predicts every copy, done and lookup item from a private copy of the page
// tables, and checks the result stream item by item under random idling.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fsgc_pkg::*;

    localparam int PAGES_PER_SEG = 32;
    localparam int TOTAL_PAGES   = 1024;
    localparam int ITEM_TARGET   = 210;
    localparam int CALM_ITEMS    = 30;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        op_t                     op;
        logic [PAGE_FIELD_W-1:0] phys;
        logic [PAGE_FIELD_W-1:0] logi;
        logic [SEG_FIELD_W-1:0]  victim;
        bit                      drain_first;
    } command_t;

    typedef struct {
        kind_t                   kind;
        logic [PAGE_FIELD_W-1:0] src;
        logic [PAGE_FIELD_W-1:0] dst;
        logic [PAGE_FIELD_W-1:0] moved;
        logic [SEG_FIELD_W-1:0]  seg;
        logic                    last;
    } page_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [KIND_W-1:0]     m_tuser;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    // Private copy of the translation tables.
    logic [PAGE_FIELD_W-1:0] map_l2p   [TOTAL_PAGES];
    logic [PAGE_FIELD_W-1:0] map_owner [TOTAL_PAGES];
    bit                      map_stale [TOTAL_PAGES];
    logic [SEG_FIELD_W-1:0]  log_seg;

    command_t     pending_cmds[$];
    page_result_t due_results[$];

    int  issued_items   = 0;
    int  accepted_items = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    bit  cmd_taken      = 1'b0;
    int  gap_left       = 0;
    int  gap_pct        = 0;
    int  gap_stretch    = 0;
    int  stall_left     = 0;
    int  stall_pct      = 0;
    int  stall_stretch  = 0;
    logic [PAGE_FIELD_W-1:0] last_logi = '0;

    flash_segment_garbage_collector #(
        .PAGES_PER_SEGMENT (PAGES_PER_SEG),
        .TOTAL_PAGES       (TOTAL_PAGES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic push_cmd(input op_t op, input int phys, input int logi,
                            input int victim, input bit drain_first);
        command_t c;
        c.op          = op;
        c.phys        = PAGE_FIELD_W'(phys);
        c.logi        = PAGE_FIELD_W'(logi);
        c.victim      = SEG_FIELD_W'(victim);
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
        issued_items++;
        if (op == OP_MAP_WRITE)
        begin
            last_logi = c.logi;
        end
    endtask

    task automatic add_result(input kind_t kind, input int src, input int dst,
                              input int moved, input logic last);
        page_result_t r;
        r.kind  = kind;
        r.src   = PAGE_FIELD_W'(src);
        r.dst   = PAGE_FIELD_W'(dst);
        r.moved = PAGE_FIELD_W'(moved);
        r.seg   = log_seg;
        r.last  = last;
        due_results.push_back(r);
    endtask

    // Applies one accepted command to the table copy and queues its results.
    task automatic apply_command(input op_t op, input int phys, input int logi,
                                 input int victim);
        int start;
        int dest;
        int pg;
        int own;
        int copies;
        phys = phys % TOTAL_PAGES;
        logi = logi % TOTAL_PAGES;
        case (op)
            OP_MAP_WRITE:
            begin
                map_l2p[logi]   = PAGE_FIELD_W'(phys);
                map_owner[phys] = PAGE_FIELD_W'(logi);
                map_stale[phys] = 1'b0;
            end
            OP_INVALIDATE:
            begin
                map_stale[phys] = 1'b1;
            end
            OP_LOOKUP:
            begin
                add_result(KIND_LOOKUP, 0, map_l2p[logi], 0, 1'b1);
            end
            default:
            begin
                start  = (victim * PAGES_PER_SEG) % TOTAL_PAGES;
                dest   = phys;
                copies = 0;
                for (int i = 0; i < PAGES_PER_SEG; i++)
                begin
                    pg = (start + i) % TOTAL_PAGES;
                    if (!map_stale[pg])
                    begin
                        own             = map_owner[pg] % TOTAL_PAGES;
                        map_l2p[own]    = PAGE_FIELD_W'(dest);
                        map_owner[dest] = PAGE_FIELD_W'(own);
                        add_result(KIND_COPY, pg, dest, own, 1'b0);
                        copies++;
                        dest = (dest + 1) % TOTAL_PAGES;
                    end
                end
                for (int i = 0; i < PAGES_PER_SEG; i++)
                begin
                    map_stale[(start + i) % TOTAL_PAGES] = 1'b0;
                end
                // With nothing copied the victim itself becomes the next write page.
                if (copies == 0)
                begin
                    add_result(KIND_DONE, start, start, 0, 1'b1);
                end
                else
                begin
                    log_seg = SEG_FIELD_W'(victim);
                    add_result(KIND_DONE, start, dest, 0, 1'b1);
                end
            end
        endcase
    endtask

    // Sampling at the rising edge: command acceptance, prediction and result checks.
    always @(posedge clk)
    begin
        page_result_t want;
        page_result_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            cmd_taken = rst_n && s_tvalid && s_tready;
            if (cmd_taken)
            begin
                accepted_items++;
                apply_command(op_t'(s_tuser), s_tdata[9:0], s_tdata[19:10],
                              s_tdata[24:20]);
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind  = kind_t'(m_tuser);
                got.src   = m_tdata[9:0];
                got.dst   = m_tdata[19:10];
                got.moved = m_tdata[29:20];
                got.seg   = m_tdata[34:30];
                got.last  = m_tlast;
                if (due_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected item kind=%0d src=%0d dst=%0d",
                                         got.kind, got.src, got.dst));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.kind !== want.kind || got.src !== want.src ||
                        got.dst !== want.dst || got.moved !== want.moved ||
                        got.seg !== want.seg || got.last !== want.last)
                    begin
                        flag_error($sformatf(
                            "got kind=%0d src=%0d dst=%0d lp=%0d seg=%0d last=%0b, %s",
                            got.kind, got.src, got.dst, got.moved, got.seg, got.last,
                            $sformatf("want kind=%0d src=%0d dst=%0d lp=%0d seg=%0d last=%0b",
                                      want.kind, want.src, want.dst, want.moved,
                                      want.seg, want.last)));
                    end
                end
            end
        end
    end

    // Command driver.
    always @(negedge clk)
    begin
        command_t nxt;
        logic     give;
        bit       calm;
        if (rst_n)
        begin
            calm = accepted_items >= issued_items - CALM_ITEMS;
            gap_stretch--;
            if (gap_stretch <= 0)
            begin
                gap_stretch = 150;
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 25;
                    default: gap_pct = 50;
                endcase
            end
            if (!(s_tvalid && !cmd_taken))
            begin
                give = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_cmds.size() != 0 &&
                         (!pending_cmds[0].drain_first || due_results.size() == 0))
                begin
                    if (!calm && $urandom_range(0, 99) < gap_pct)
                    begin
                        gap_left = $urandom_range(0, 8);
                    end
                    else
                    begin
                        nxt  = pending_cmds.pop_front();
                        give = 1'b1;
                    end
                end
                s_tvalid <= give;
                if (give)
                begin
                    s_tuser <= nxt.op;
                    s_tdata <= {7'b0, nxt.victim, nxt.logi, nxt.phys};
                end
            end
        end
    end

    // Result-side back-pressure.
    always @(negedge clk)
    begin
        bit calm;
        if (rst_n)
        begin
            calm = accepted_items >= issued_items - CALM_ITEMS;
            stall_stretch--;
            if (stall_stretch <= 0)
            begin
                stall_stretch = 200;
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 25;
                    default: stall_pct = 45;
                endcase
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int v;
        int start;
        int n;
        int reserve;
        for (int i = 0; i < TOTAL_PAGES; i++)
        begin
            map_l2p[i]   = '0;
            map_owner[i] = '0;
            map_stale[i] = 1'b0;
        end
        log_seg = '0;

        // Directed part: field extremes, every opcode, wrapping reserve pointer.
        push_cmd(OP_LOOKUP,     0,    0,    0,  1'b0);
        push_cmd(OP_MAP_WRITE,  1023, 0,    31, 1'b0);
        push_cmd(OP_MAP_WRITE,  0,    1023, 0,  1'b0);
        push_cmd(OP_LOOKUP,     0,    1023, 31, 1'b0);
        push_cmd(OP_LOOKUP,     1023, 0,    0,  1'b0);
        push_cmd(OP_INVALIDATE, 0,    1023, 31, 1'b0);
        push_cmd(OP_INVALIDATE, 1023, 0,    0,  1'b0);
        // The reserve run wraps past the last page and lands inside the victim.
        push_cmd(OP_COLLECT,    1010, 0,    0,  1'b0);
        push_cmd(OP_LOOKUP,     0,    1023, 0,  1'b0);
        push_cmd(OP_LOOKUP,     0,    0,    0,  1'b0);
        push_cmd(OP_COLLECT,    0,    1023, 31, 1'b0);
        push_cmd(OP_COLLECT,    512,  0,    31, 1'b0);
        push_cmd(OP_MAP_WRITE,  682,  341,  21, 1'b0);
        push_cmd(OP_INVALIDATE, 341,  682,  10, 1'b0);
        push_cmd(OP_LOOKUP,     0,    341,  0,  1'b0);
        push_cmd(OP_COLLECT,    1023, 1023, 10, 1'b0);
        push_cmd(OP_LOOKUP,     1023, 682,  31, 1'b0);

        // A segment left with no valid page at all, after a full drain.
        v     = $urandom_range(0, 31);
        start = v * PAGES_PER_SEG;
        for (int off = 0; off < PAGES_PER_SEG; off++)
        begin
            push_cmd(OP_INVALIDATE, start + off, $urandom_range(0, 1023),
                     $urandom_range(0, 31), off == 0);
        end
        push_cmd(OP_COLLECT, $urandom_range(0, 1023), $urandom_range(0, 1023), v, 1'b0);
        push_cmd(OP_LOOKUP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 31), 1'b0);

        while (issued_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // Populate and stale part of one segment, then collect it.
                    v     = $urandom_range(0, 31);
                    start = v * PAGES_PER_SEG;
                    n     = $urandom_range(1, 10);
                    for (int k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 2))
                            0: push_cmd(OP_MAP_WRITE,
                                        start + $urandom_range(0, PAGES_PER_SEG - 1),
                                        $urandom_range(0, 1023), $urandom_range(0, 31),
                                        issued_items == 120);
                            1: push_cmd(OP_INVALIDATE,
                                        start + $urandom_range(0, PAGES_PER_SEG - 1),
                                        $urandom_range(0, 1023), $urandom_range(0, 31),
                                        issued_items == 120);
                            default: push_cmd(OP_LOOKUP, $urandom_range(0, 1023),
                                              $urandom_range(0, 1) ? last_logi :
                                              $urandom_range(0, 1023),
                                              $urandom_range(0, 31), issued_items == 120);
                        endcase
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        reserve = start + $urandom_range(0, PAGES_PER_SEG - 1);
                    end
                    else
                    begin
                        reserve = $urandom_range(0, 1023);
                    end
                    push_cmd(OP_COLLECT, reserve, $urandom_range(0, 1023), v, 1'b0);
                    push_cmd(OP_LOOKUP, $urandom_range(0, 1023), last_logi,
                             $urandom_range(0, 31), 1'b0);
                end
                6, 7:
                begin
                    push_cmd(OP_LOOKUP, $urandom_range(0, 1023),
                             $urandom_range(0, 1) ? last_logi : $urandom_range(0, 1023),
                             $urandom_range(0, 31), 1'b0);
                end
                8:
                begin
                    push_cmd($urandom_range(0, 1) ? OP_MAP_WRITE : OP_INVALIDATE,
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 31), 1'b0);
                end
                default:
                begin
                    push_cmd(OP_COLLECT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 31), 1'b0);
                end
            endcase
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
